FILE: src/gss_pkg.sv
// Package: shared types, widths and codes for the Gauss-Seidel stencil solver.
package gss_pkg;

	localparam int VAL_W    = 32;
	localparam int NODE_W   = 10;
	localparam int MAX_NODES = 1024;
	localparam int GRID_W   = 6;
	localparam int ITER_W   = 16;
	localparam int TOL_W    = 31;
	localparam int COEF_CNT = 6;
	localparam int COEF_W   = COEF_CNT * VAL_W;
	localparam int PROD_W   = 2 * VAL_W;
	localparam int ACC_W    = 51;
	localparam int NUM_W    = 47;
	localparam int DVD_W    = NUM_W + 16;
	localparam int CNT_W    = 6;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_SOLVE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TOL    = 2'd2;
	localparam logic [1:0] REG_MAXIT  = 2'd3;

	localparam logic [1:0] SLOT_S = 2'd0;
	localparam logic [1:0] SLOT_W = 2'd1;
	localparam logic [1:0] SLOT_E = 2'd2;
	localparam logic [1:0] SLOT_N = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_LAT, S_CHECK, S_NODE_RD, S_NODE_LAT, S_SLOT, S_NB,
		S_MUL, S_ACC, S_DIV_INIT, S_DIV, S_WRITE, S_SWEEP_END, S_DONE
	} state_t;

endpackage

FILE: src/gss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/gauss_seidel_stencil_solver_core.sv
// Timing: a load is written as it is accepted; a read passes S_RD_LAT and S_DONE, and S_DONE
// raises out_valid once the output is free. A solve passes S_CHECK and S_SWEEP_END per sweep
// and per node fetches, forms a bit-serial product per neighbour slot (all four in central rows,
// one in the bottom and top rows), steps over other slots, divides (restoring) and writes back.
// Throughput: one load per cycle; a read or solve holds the input until done.
// Reset: asynchronous, active low; clears control state and restores the
// configuration defaults; node stores hold undefined data until loaded.
module gauss_seidel_stencil_solver_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic [gss_pkg::NODE_W-1:0]   node_index,
	input  logic signed [gss_pkg::VAL_W-1:0] coef_south,
	input  logic signed [gss_pkg::VAL_W-1:0] coef_west,
	input  logic signed [gss_pkg::VAL_W-1:0] coef_east,
	input  logic signed [gss_pkg::VAL_W-1:0] coef_north,
	input  logic signed [gss_pkg::VAL_W-1:0] coef_center,
	input  logic signed [gss_pkg::VAL_W-1:0] rhs,
	input  logic signed [gss_pkg::VAL_W-1:0] initial_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         result_kind,
	output logic signed [gss_pkg::VAL_W-1:0] node_value,
	output logic [gss_pkg::ITER_W-1:0]   iterations,
	output logic                         converged
);
	import gss_pkg::*;

	state_t state_q, state_d;

	logic [GRID_W-1:0] width_q, height_q;
	logic [TOL_W-1:0]  tol_q;
	logic [ITER_W-1:0] maxit_q;

	logic [ITER_W-1:0] sweep_q;
	logic              conv_q;
	logic [VAL_W-1:0]  lc_q;
	logic [NODE_W-1:0] n_q;
	logic [GRID_W-1:0] row_q, col_q;
	logic [1:0]        slot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  old_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [VAL_W-1:0]  mcand_q, mplier_q;
	logic [PROD_W-1:0] prod_q;
	logic              pneg_q;
	logic [DVD_W-1:0]  dvd_q, quo_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  ud_q;
	logic              nneg_q, nzero_q, dneg_q, zden_q;
	logic              pend_kind_q;
	logic [VAL_W-1:0]  pend_val_q;

	logic              out_valid_q, kind_q, conv_out_q;
	logic [VAL_W-1:0]  val_out_q;
	logic [ITER_W-1:0] iter_out_q;

	// memories
	logic              coef_we, sol_we;
	logic [NODE_W-1:0] coef_waddr, sol_waddr, sol_raddr;
	logic [COEF_W-1:0] coef_wdata, coef_rdata;
	logic [VAL_W-1:0]  sol_wdata, sol_rdata;

	gss_ram #(.WIDTH(COEF_W), .DEPTH(MAX_NODES)) u_coef_ram (
		.clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
		.raddr(n_q), .rdata(coef_rdata)
	);

	gss_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_sol_ram (
		.clk(clk), .we(sol_we), .waddr(sol_waddr), .wdata(sol_wdata),
		.raddr(sol_raddr), .rdata(sol_rdata)
	);

	logic [VAL_W-1:0] c_south, c_west, c_east, c_north, c_diag, c_rhs;
	assign c_south = coef_rdata[0*VAL_W +: VAL_W];
	assign c_west  = coef_rdata[1*VAL_W +: VAL_W];
	assign c_east  = coef_rdata[2*VAL_W +: VAL_W];
	assign c_north = coef_rdata[3*VAL_W +: VAL_W];
	assign c_diag  = coef_rdata[4*VAL_W +: VAL_W];
	assign c_rhs   = coef_rdata[5*VAL_W +: VAL_W];

	// geometry
	logic [2*GRID_W-1:0] area;
	logic                geom_ok, last_node, last_col, slot_en;
	logic [NODE_W-1:0]   w_ext, nb_addr, last_n;
	logic [VAL_W-1:0]    slot_coef;

	assign area    = 12'(width_q) * 12'(height_q);
	assign geom_ok = (width_q != '0) && (height_q >= GRID_W'(2)) &&
	                 (area <= 12'(MAX_NODES));
	assign last_n  = NODE_W'(area - 12'd1);
	assign last_node = (n_q == last_n);
	assign last_col  = (col_q == width_q - GRID_W'(1));
	assign w_ext   = NODE_W'(width_q);

	always_comb begin
		case (slot_q)
			SLOT_S:  begin nb_addr = n_q - w_ext;     slot_coef = c_south; end
			SLOT_W:  begin nb_addr = n_q - NODE_W'(1); slot_coef = c_west;  end
			SLOT_E:  begin nb_addr = n_q + NODE_W'(1); slot_coef = c_east;  end
			default: begin nb_addr = n_q + w_ext;     slot_coef = c_north; end
		endcase
	end

	// bottom row sees only north, top row only south
	always_comb begin
		if (row_q == '0) begin
			slot_en = (slot_q == SLOT_N);
		end else if (row_q == height_q - GRID_W'(1)) begin
			slot_en = (slot_q == SLOT_S);
		end else begin
			slot_en = 1'b1;
		end
	end

	// numerator clamp and sign
	localparam logic signed [ACC_W-1:0] NUM_CLAMP = ACC_W'((64'd1 << NUM_W) - 64'd1);
	logic signed [ACC_W-1:0] num_cl;
	logic [ACC_W-1:0]        num_mag;
	always_comb begin
		if (acc_q > NUM_CLAMP) begin
			num_cl = NUM_CLAMP;
		end else if (acc_q < -NUM_CLAMP) begin
			num_cl = -NUM_CLAMP;
		end else begin
			num_cl = acc_q;
		end
		num_mag = num_cl[ACC_W-1] ? ACC_W'(-num_cl) : ACC_W'(num_cl);
	end

	// divider step
	logic [VAL_W:0] rem_sh;
	logic           rem_ge;
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, ud_q};

	// new value with saturation
	localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
	logic [VAL_W-1:0] nv;
	logic [VAL_W:0]   diff;
	logic [VAL_W-1:0] dmag;
	always_comb begin
		if (zden_q) begin
			nv = nzero_q ? '0 : (nneg_q ? VMIN : VMAX);
		end else if (nneg_q != dneg_q) begin
			nv = (quo_q > DVD_W'(VMIN)) ? VMIN : VAL_W'(-quo_q);
		end else begin
			nv = (quo_q > DVD_W'(VMAX)) ? VMAX : quo_q[VAL_W-1:0];
		end
		diff = {old_q[VAL_W-1], old_q} - {nv[VAL_W-1], nv};
		dmag = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
	end

	logic in_acc, out_free;
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && action == ACT_SOLVE) state_d = S_CHECK;
				else if (in_valid && action == ACT_READ) state_d = S_RD_LAT;
			end
			S_RD_LAT:   state_d = S_DONE;
			S_CHECK: begin
				if (!geom_ok || sweep_q >= maxit_q || conv_q) state_d = S_DONE;
				else state_d = S_NODE_RD;
			end
			S_NODE_RD:  state_d = S_NODE_LAT;
			S_NODE_LAT: state_d = S_SLOT;
			S_SLOT: begin
				if (slot_en) state_d = S_NB;
				else if (slot_q == SLOT_N) state_d = S_DIV_INIT;
			end
			S_NB:       state_d = S_MUL;
			S_MUL:      if (cnt_q == CNT_W'(VAL_W - 1)) state_d = S_ACC;
			S_ACC:      state_d = (slot_q == SLOT_N) ? S_DIV_INIT : S_SLOT;
			S_DIV_INIT: state_d = (ud_q == '0 && c_diag == '0) ? S_WRITE : S_DIV;
			S_DIV:      if (cnt_q == CNT_W'(DVD_W - 1)) state_d = S_WRITE;
			S_WRITE:    state_d = last_node ? S_SWEEP_END : S_NODE_RD;
			S_SWEEP_END: state_d = S_CHECK;
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cfg_ready  = 1'b1;
		coef_we    = 1'b0;
		coef_waddr = node_index;
		coef_wdata = {rhs, coef_center, coef_north, coef_east, coef_west, coef_south};
		sol_we     = 1'b0;
		sol_waddr  = node_index;
		sol_wdata  = initial_value;
		sol_raddr  = node_index;
		case (state_q)
			S_IDLE: begin
				coef_we = in_valid && action == ACT_LOAD;
				sol_we  = in_valid && action == ACT_LOAD;
			end
			S_NODE_RD: sol_raddr = n_q;
			S_SLOT:    sol_raddr = nb_addr;
			S_WRITE: begin
				sol_we    = 1'b1;
				sol_waddr = n_q;
				sol_wdata = nv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= GRID_W'(32);
			height_q    <= GRID_W'(32);
			tol_q       <= TOL_W'(66);
			maxit_q     <= ITER_W'(1000);
			out_valid_q <= 1'b0;
			sweep_q     <= '0;
			conv_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[GRID_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[GRID_W-1:0];
					REG_TOL:    tol_q    <= cfg_data[TOL_W-1:0];
					REG_MAXIT:  maxit_q  <= cfg_data[ITER_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == S_IDLE && in_acc && action == ACT_SOLVE) begin
				sweep_q <= '0;
				conv_q  <= 1'b0;
			end
			if (state_q == S_SWEEP_END) begin
				sweep_q <= sweep_q + ITER_W'(1);
				conv_q  <= {1'b0, tol_q} > lc_q;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pend_kind_q <= (action == ACT_READ) ? KIND_READ : KIND_STATUS;
				pend_val_q  <= '0;
			end
			S_RD_LAT: pend_val_q <= sol_rdata;
			S_CHECK: begin
				lc_q  <= '0;
				n_q   <= '0;
				row_q <= '0;
				col_q <= '0;
			end
			S_NODE_LAT: begin
				old_q  <= sol_rdata;
				acc_q  <= ACC_W'($signed(c_rhs));
				slot_q <= SLOT_S;
				ud_q   <= c_diag[VAL_W-1] ? VAL_W'(-c_diag) : c_diag;
				dneg_q <= c_diag[VAL_W-1];
			end
			S_SLOT: begin
				if (!slot_en && slot_q != SLOT_N) slot_q <= slot_q + 2'd1;
			end
			S_NB: begin
				mcand_q  <= slot_coef[VAL_W-1] ? VAL_W'(-slot_coef) : slot_coef;
				mplier_q <= sol_rdata[VAL_W-1] ? VAL_W'(-sol_rdata) : sol_rdata;
				pneg_q   <= slot_coef[VAL_W-1] != sol_rdata[VAL_W-1];
				prod_q   <= '0;
				cnt_q    <= '0;
			end
			S_MUL: begin
				// shift-add, multiplier bits MSB first
				prod_q   <= {prod_q[PROD_W-2:0], 1'b0} +
				            (mplier_q[VAL_W-1] ? PROD_W'(mcand_q) : '0);
				mplier_q <= {mplier_q[VAL_W-2:0], 1'b0};
				cnt_q    <= cnt_q + CNT_W'(1);
			end
			S_ACC: begin
				acc_q  <= pneg_q ? acc_q - ACC_W'(prod_q[PROD_W-1:16])
				                 : acc_q + ACC_W'(prod_q[PROD_W-1:16]);
				slot_q <= slot_q + 2'd1;
			end
			S_DIV_INIT: begin
				dvd_q   <= {num_mag[NUM_W-1:0], 16'd0};
				rem_q   <= '0;
				quo_q   <= '0;
				cnt_q   <= '0;
				nneg_q  <= num_cl[ACC_W-1];
				nzero_q <= (num_cl == '0);
				zden_q  <= (c_diag == '0);
			end
			S_DIV: begin
				rem_q <= rem_ge ? VAL_W'(rem_sh - {1'b0, ud_q}) : rem_sh[VAL_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], rem_ge};
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_WRITE: begin
				if (dmag > lc_q) lc_q <= dmag;
				n_q <= n_q + NODE_W'(1);
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + GRID_W'(1);
				end else begin
					col_q <= col_q + GRID_W'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					kind_q     <= pend_kind_q;
					val_out_q  <= pend_val_q;
					iter_out_q <= (pend_kind_q == KIND_READ) ? '0 : sweep_q;
					conv_out_q <= (pend_kind_q == KIND_READ) ? 1'b0 : conv_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign node_value  = val_out_q;
	assign iterations  = iter_out_q;
	assign converged   = conv_out_q;

	a_conv_needs_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_STATUS && converged |-> iterations != '0)
		else $error("converged reported with no sweep");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_READ |-> !converged && iterations == '0)
		else $error("read item carries status fields");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> cnt_q < CNT_W'(VAL_W))
		else $error("multiplier ran past its width");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |=> state_q == S_NODE_RD || state_q == S_SWEEP_END)
		else $error("node update not followed by next node or sweep end");

endmodule

FILE: sim/tb_gauss_seidel_stencil_solver_core.sv
// Testbench for the Gauss-Seidel stencil solver core: random loads, solves and reads checked against a bit-exact predictor.
module tb_gauss_seidel_stencil_solver_core;
	timeunit 1ns;
	timeprecision 1ps;

	import gss_pkg::*;

	localparam longint          VAL_MAX   = 64'sd2147483647;
	localparam longint          VAL_MIN   = -64'sd2147483648;
	localparam longint unsigned VAL_MAXU  = 64'd2147483647;
	localparam longint          NUM_LIM   = 64'sd140737488355327;
	localparam int              LIMIT     = 40_000_000;
	localparam int              ITEM_GOAL = 1750;
	localparam logic [1:0]      ACT_BAD   = 2'd3;

	typedef struct packed {
		logic [1:0]               act;
		logic [NODE_W-1:0]        idx;
		logic signed [VAL_W-1:0]  cs, cw, ce, cn, cc, rh, iv;
	} node_op_t;

	typedef struct packed {
		logic              kind;
		logic [VAL_W-1:0]  value;
		logic [ITER_W-1:0] iters;
		logic              conv;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_WIDTH;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic signed [VAL_W-1:0] node_value;
	logic [ITER_W-1:0] iterations;
	logic converged;
	node_op_t cur_op = '0;
	logic in_fire = 1'b0;
	bit calm = 1'b0;

	node_op_t pending_ops[$];
	reply_t   due_replies[$];
	int       mismatches = 0;
	int       cycles = 0;

	// predictor state
	logic [GRID_W-1:0] g_w = 6'd32, g_h = 6'd32;
	logic [TOL_W-1:0]  g_tol = 31'd66;
	logic [ITER_W-1:0] g_maxit = 16'd1000;
	longint sx[MAX_NODES], wx[MAX_NODES], ex[MAX_NODES], nx[MAX_NODES];
	longint dg[MAX_NODES], rv[MAX_NODES], sol[MAX_NODES];
	longint unsigned worst;

	gauss_seidel_stencil_solver_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(cur_op.act), .node_index(cur_op.idx),
		.coef_south(cur_op.cs), .coef_west(cur_op.cw), .coef_east(cur_op.ce),
		.coef_north(cur_op.cn), .coef_center(cur_op.cc), .rhs(cur_op.rh),
		.initial_value(cur_op.iv),
		.out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
		.node_value(node_value), .iterations(iterations), .converged(converged)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned abs64(longint a);
		return a < 0 ? longint'(-a) : a;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint unsigned p;
		p = (abs64(a) * abs64(b)) >> 16;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint fx_div(longint num, longint den);
		longint unsigned un, ud, q;
		if (num > NUM_LIM) num = NUM_LIM;
		if (num < -NUM_LIM) num = -NUM_LIM;
		if (den == 0) return num > 0 ? VAL_MAX : (num < 0 ? VAL_MIN : 0);
		un = abs64(num);
		ud = abs64(den);
		q = (un << 16) / ud;
		if ((num < 0) != (den < 0)) return q > VAL_MAXU + 1 ? VAL_MIN : -longint'(q);
		return q > VAL_MAXU ? VAL_MAX : longint'(q);
	endfunction

	function automatic void relax(int n, longint num);
		longint nv;
		longint unsigned d;
		nv = fx_div(num, dg[n]);
		d = abs64(sol[n] - nv);
		sol[n] = nv;
		if (d > worst) worst = d;
	endfunction

	function automatic reply_t solve_grid();
		int w, h, n, cnt;
		bit conv;
		w = g_w;
		h = g_h;
		cnt = 0;
		conv = 1'b0;
		if (w >= 1 && h >= 2 && w * h <= MAX_NODES) begin
			while (cnt < g_maxit && !conv) begin
				worst = 0;
				for (int i = 0; i < w; i++)
					relax(i, rv[i] + fx_mul(nx[i], sol[i + w]));
				for (int j = 1; j + 1 < h; j++)
					for (int i = 0; i < w; i++) begin
						n = j * w + i;
						relax(n, rv[n] + fx_mul(sx[n], sol[n - w]) + fx_mul(wx[n], sol[n - 1])
							+ fx_mul(ex[n], sol[n + 1]) + fx_mul(nx[n], sol[n + w]));
					end
				for (int i = 0; i < w; i++) begin
					n = (h - 1) * w + i;
					relax(n, rv[n] + fx_mul(sx[n], sol[n - w]));
				end
				conv = worst < g_tol;
				cnt++;
			end
		end
		return '{KIND_STATUS, '0, cnt[ITER_W-1:0], conv};
	endfunction

	function automatic void solver_apply(node_op_t op);
		case (op.act)
			ACT_LOAD: begin
				sx[op.idx] = $signed(op.cs); wx[op.idx] = $signed(op.cw);
				ex[op.idx] = $signed(op.ce); nx[op.idx] = $signed(op.cn);
				dg[op.idx] = $signed(op.cc); rv[op.idx] = $signed(op.rh);
				sol[op.idx] = $signed(op.iv);
			end
			ACT_SOLVE: due_replies.push_back(solve_grid());
			ACT_READ:  due_replies.push_back('{KIND_READ, sol[op.idx][31:0], '0, 1'b0});
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// accept side
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) solver_apply(cur_op);
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
					cur_op <= pending_ops.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= calm || $urandom_range(99) >= 36;
		end
	end

	always @(posedge clk) begin
		reply_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{result_kind, node_value, iterations, converged};
			if (due_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result kind=%0d value=%h iters=%0d conv=%0d",
					got.kind, got.value, got.iters, got.conv);
			end else begin
				want = due_replies.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind=%0d value=%h iters=%0d conv=%0d, got kind=%0d value=%h iters=%0d conv=%0d",
							want.kind, want.value, want.iters, want.conv,
							got.kind, got.value, got.iters, got.conv);
				end
			end
		end
	end

	// stimulus
	bit loaded[MAX_NODES];
	int n_items = 0;

	task automatic reg_write(logic [1:0] idx, logic [31:0] value, logic [31:0] junk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value | junk;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WIDTH:  g_w = value[GRID_W-1:0];
			REG_HEIGHT: g_h = value[GRID_W-1:0];
			REG_TOL:    g_tol = value[TOL_W-1:0];
			REG_MAXIT:  g_maxit = value[ITER_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(int w, int h, int unsigned tol, int maxit);
		bit messy;
		messy = $urandom_range(3) == 0;
		reg_write(REG_WIDTH, w, messy ? 32'({$urandom, 6'b0}) : 32'd0);
		reg_write(REG_HEIGHT, h, messy ? 32'({$urandom, 6'b0}) : 32'd0);
		reg_write(REG_TOL, tol, messy ? {$urandom_range(1) != 0, 31'b0} : 32'd0);
		reg_write(REG_MAXIT, maxit, messy ? 32'({$urandom, 16'b0}) : 32'd0);
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || in_valid || due_replies.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [31:0] small_val(int unsigned span);
		return $urandom_range(2 * span) - span;
	endfunction

	// tame nodes are diagonally dominant so that sweeps contract
	function automatic void push_load(int idx, bit tame);
		node_op_t op;
		op.act = ACT_LOAD;
		op.idx = NODE_W'(idx);
		if (tame) begin
			op.cs = small_val(32'h4000); op.cw = small_val(32'h4000);
			op.ce = small_val(32'h4000); op.cn = small_val(32'h4000);
			op.cc = ($urandom_range(1) ? 1 : -1) * ($urandom_range(32'h10000) + 32'h40000);
			op.rh = small_val(32'h40000); op.iv = small_val(32'h80000);
		end else begin
			op.cs = $urandom; op.cw = $urandom; op.ce = $urandom; op.cn = $urandom;
			op.cc = $urandom_range(7) == 0 ? 0 : $urandom;
			op.rh = $urandom; op.iv = $urandom;
		end
		loaded[idx] = 1'b1;
		pending_ops.push_back(op);
		n_items++;
	endfunction

	function automatic void push_op(logic [1:0] act, int idx);
		node_op_t op;
		logic [255:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		op = noise[$bits(node_op_t)-1:0];
		op.act = act;
		op.idx = NODE_W'(idx);
		pending_ops.push_back(op);
		if (act != ACT_BAD) n_items++;
	endfunction

	function automatic void push_fixed(int idx, logic [31:0] v, logic [31:0] center);
		node_op_t op;
		op = '{ACT_LOAD, NODE_W'(idx), v, v, v, v, center, v, v};
		loaded[idx] = 1'b1;
		pending_ops.push_back(op);
		n_items++;
	endfunction

	function automatic int pick_loaded(int nodes);
		int idx;
		if ($urandom_range(4) == 0)
			for (int k = 0; k < 50; k++) begin
				idx = $urandom_range(MAX_NODES - 1);
				if (loaded[idx]) return idx;
			end
		return $urandom_range(nodes - 1);
	endfunction

	initial begin
		int w, h, nodes, maxit, extra, r;
		int unsigned tol;
		bit tame, big_done;
		big_done = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero diagonal, zero numerator, odd geometry
		set_grid(2, 2, 66, 1);
		push_fixed(0, 32'h7fffffff, 32'h7fffffff);
		push_fixed(1, 32'h80000000, 32'h80000000);
		push_load(2, 1'b1);
		pending_ops[$].cc = 0;
		push_fixed(3, 32'h0, 32'h0);
		push_op(ACT_SOLVE, 0);
		for (int i = 0; i < 4; i++) push_op(ACT_READ, i);
		push_op(ACT_BAD, 5);
		push_load(1023, 1'b0);
		push_op(ACT_READ, 1023);
		drain();
		set_grid(2, 2, 66, 0);
		push_op(ACT_SOLVE, 0);
		drain();
		set_grid(0, 2, 66, 2);
		push_op(ACT_SOLVE, 0);
		drain();
		set_grid(63, 63, 66, 2);
		push_op(ACT_SOLVE, 0);
		drain();
		set_grid(3, 1, 66, 2);
		push_op(ACT_SOLVE, 0);
		drain();
		set_grid(2, 0, 0, 3);
		push_op(ACT_SOLVE, 0);
		drain();
		set_grid(2, 2, 32'h7fffffff, 65535);
		for (int i = 0; i < 4; i++) push_load(i, 1'b1);
		push_op(ACT_SOLVE, 0);
		push_op(ACT_READ, 3);
		drain();
		set_grid(2, 2, 0, 3);
		push_op(ACT_SOLVE, 0);
		drain();

		while (n_items < ITEM_GOAL) begin
			calm = n_items > 700 && n_items < 900;
			r = $urandom_range(99);
			if (!big_done && n_items > 1000) begin
				w = 32; h = 32; big_done = 1'b1;
			end else if (r < 3) begin
				w = 32; h = 2;
			end else if (r < 6) begin
				w = 1; h = 32;
			end else begin
				w = $urandom_range(1, 4); h = $urandom_range(2, 4);
			end
			nodes = w * h;
			tame = $urandom_range(99) < 85;
			r = $urandom_range(99);
			if (r < 40) tol = $urandom_range(32'h7fffffff, 32'h10000000);
			else if (r < 70) tol = 66;
			else if (r < 90) tol = $urandom_range(65535);
			else tol = 0;
			if (nodes > 16) maxit = $urandom_range(1, 2);
			else if (tol == 0 || !tame) maxit = $urandom_range(1, 3);
			else maxit = $urandom_range(1, 8);
			set_grid(w, h, tol, maxit);
			for (int i = 0; i < nodes; i++) push_load(i, tame || $urandom_range(9) == 0);
			extra = $urandom_range(4, 20);
			for (int k = 0; k < extra; k++) begin
				r = $urandom_range(99);
				if (r < 50) push_op(ACT_READ, pick_loaded(nodes));
				else if (r < 85) push_load($urandom_range(MAX_NODES - 1), $urandom_range(1));
				else if (r < 90) push_op(ACT_BAD, $urandom_range(MAX_NODES - 1));
				else push_op(ACT_SOLVE, $urandom_range(MAX_NODES - 1));
			end
			push_op(ACT_SOLVE, $urandom_range(MAX_NODES - 1));
			for (int k = $urandom_range(2, 5); k > 0; k--) push_op(ACT_READ, pick_loaded(nodes));
			drain();
		end
		calm = 1'b0;
		drain();
		if (mismatches == 0 && due_replies.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
src/gss_pkg.sv
src/gss_ram.sv
src/gauss_seidel_stencil_solver_core.sv
sim/tb_gauss_seidel_stencil_solver_core.sv
